[design/pidtf_pkg.sv]
// Shared constants for the three-form PID controller.
package pidtf_pkg;

    // Default parameter values
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int DRIVE_W    = 32;
    localparam int INTEG_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd6;

    // Form codes
    localparam logic [1:0] FORM_COMBINED = 2'd0;
    localparam logic [1:0] FORM_TEXTBOOK = 2'd1;
    localparam logic [1:0] FORM_POSITION = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

[design/pid_controller_three_form_unit.sv]
// Three-form PID controller: combined incremental, textbook incremental, positional.
//
// Takes one sample pair per cycle and returns one drive value per sample, in
// order. Items pass through an input register, a stage
// holding the three gain products (one multiplier per gain, operands chosen by
// form), and an output register that sums, updates the positional integral
// and clamps. Throughput is one item per clock while m_axis_tready is high;
// the integral add-and-clamp loop lies within the last stage.
// Form code 3 behaves as positional. Configuration is written through the
// cfg port (always ready) and must only change while no item is in flight.
module pid_controller_three_form_unit
    import pidtf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input item
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // measured, setpoint
    input  logic [0:0]            s_axis_tuser,               // clear
    // result item
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DRIVE_W-1:0]    m_axis_tdata,               // drive
    output logic [0:0]            m_axis_tuser,               // saturated
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int E_W    = SW + 1;             // setpoint - measured
    localparam int OP_W   = SW + 3;             // widest multiplier operand
    localparam int PROD_W = GAIN_W + OP_W;
    localparam int TERM_W = PROD_W + 1;         // room for negation
    localparam int ACC_W  = ((TERM_W > INTEG_W) ? TERM_W : INTEG_W) + 3;

    // ---------------- configuration ----------------
    logic [1:0]                form_reg;
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [LIMIT_W-1:0]        inc_limit_reg, pos_limit_reg, int_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_reg      <= FORM_COMBINED;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            inc_limit_reg <= LIMIT_RESET;
            pos_limit_reg <= LIMIT_RESET;
            int_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FORM:      form_reg      <= cfg_data[1:0];
                CFG_KP:        kp_reg        <= cfg_data[GAIN_W-1:0];
                CFG_KI:        ki_reg        <= cfg_data[GAIN_W-1:0];
                CFG_KD:        kd_reg        <= cfg_data[GAIN_W-1:0];
                CFG_INC_LIMIT: inc_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_POS_LIMIT: pos_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_INT_LIMIT: int_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow ----------------
    logic a_valid_reg, b_valid_reg, out_valid_reg;
    logic a_ready, b_ready, c_ready;

    assign c_ready       = !out_valid_reg || m_axis_tready;
    assign b_ready       = !b_valid_reg || c_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;

    wire a_load = s_axis_tvalid && a_ready;
    wire b_load = a_valid_reg && b_ready;
    wire c_load = b_valid_reg && c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg   <= s_axis_tvalid;
            if (b_ready) b_valid_reg   <= a_valid_reg;
            if (c_ready) out_valid_reg <= b_valid_reg;
        end
    end

    // ---------------- stage A: input register ----------------
    logic signed [SW-1:0] a_meas_reg, a_setp_reg;
    logic                 a_clear_reg;

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_meas_reg  <= s_axis_tdata[SW-1:0];
            a_setp_reg  <= s_axis_tdata[2*SW-1:SW];
            a_clear_reg <= s_axis_tuser[0];
        end
    end

    // ---------------- stage B: error terms and products ----------------
    logic signed [E_W-1:0]    last_err_reg, prev_err_reg;
    logic signed [E_W-1:0]    err;
    logic signed [OP_W-1:0]   d1, d2;
    logic signed [OP_W-1:0]   op_p, op_i, op_d;
    logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
    logic signed [TERM_W-1:0] term_p, term_i, term_d, term_i_shr;
    logic                     a_pos;

    always_comb begin
        a_pos = form_reg[1];
        err   = E_W'(a_setp_reg) - E_W'(a_meas_reg);
        d1    = OP_W'(err) - OP_W'(last_err_reg);
        d2    = OP_W'(err) - (OP_W'(last_err_reg) <<< 1) + OP_W'(prev_err_reg);
        if (a_pos) begin
            op_p = OP_W'(err);
            op_i = OP_W'(err);
            op_d = d1;
        end else if (form_reg == FORM_TEXTBOOK) begin
            op_p = d1;
            op_i = OP_W'(err);
            op_d = d2;
        end else begin
            op_p = OP_W'(err);
            op_i = OP_W'(last_err_reg);
            op_d = OP_W'(prev_err_reg);
        end
        prod_p     = PROD_W'(kp_reg) * op_p;
        prod_i     = PROD_W'(ki_reg) * op_i;
        prod_d     = PROD_W'(kd_reg) * op_d;
        term_p     = TERM_W'(prod_p >>> GAIN_FRAC_BITS);
        term_i_shr = TERM_W'(prod_i >>> GAIN_FRAC_BITS);
        term_d     = TERM_W'(prod_d >>> GAIN_FRAC_BITS);
        // combined form subtracts the e[k-1] term
        term_i     = (form_reg == FORM_COMBINED) ? -term_i_shr : term_i_shr;
    end

    logic signed [TERM_W-1:0] b_tp_reg, b_ti_reg, b_td_reg;
    logic                     b_clear_reg, b_pos_reg;

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_tp_reg    <= term_p;
            b_ti_reg    <= term_i;
            b_td_reg    <= term_d;
            b_clear_reg <= a_clear_reg;
            b_pos_reg   <= a_pos;
        end
    end

    // error history follows items in order as they leave stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            prev_err_reg <= '0;
        end else if (b_load) begin
            if (a_clear_reg) begin
                last_err_reg <= '0;
                prev_err_reg <= '0;
            end else begin
                last_err_reg <= err;
                if (!a_pos) prev_err_reg <= last_err_reg;
            end
        end
    end

    // ---------------- stage C: integral, sum, clamp ----------------
    logic signed [INTEG_W-1:0] integral_sum_reg, integral_next;
    logic signed [ACC_W-1:0]   isum_raw, ilim, raw, olim;
    logic                      sat_next;
    logic signed [DRIVE_W-1:0] drive_next;

    always_comb begin
        isum_raw = ACC_W'(integral_sum_reg) + ACC_W'(b_ti_reg);
        ilim     = ACC_W'({1'b0, int_limit_reg});
        if (isum_raw > ilim)
            integral_next = INTEG_W'(ilim);
        else if (isum_raw < -ilim)
            integral_next = INTEG_W'(-ilim);
        else
            integral_next = INTEG_W'(isum_raw);

        if (b_pos_reg) begin
            raw  = ACC_W'(b_tp_reg) + ACC_W'(b_td_reg) + ACC_W'(integral_next);
            olim = ACC_W'({1'b0, pos_limit_reg});
        end else begin
            raw  = ACC_W'(b_tp_reg) + ACC_W'(b_ti_reg) + ACC_W'(b_td_reg);
            olim = ACC_W'({1'b0, inc_limit_reg});
        end

        sat_next = 1'b0;
        if (raw > olim) begin
            drive_next = DRIVE_W'(olim);
            sat_next   = 1'b1;
        end else if (raw < -olim) begin
            drive_next = DRIVE_W'(-olim);
            sat_next   = 1'b1;
        end else begin
            drive_next = DRIVE_W'(raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_sum_reg <= '0;
        end else if (c_load) begin
            if (b_clear_reg)
                integral_sum_reg <= '0;
            else if (b_pos_reg)
                integral_sum_reg <= integral_next;
        end
    end

    logic [DRIVE_W-1:0] drive_reg;
    logic               sat_reg;

    always_ff @(posedge aclk) begin
        if (c_load) begin
            drive_reg <= b_clear_reg ? '0 : drive_next;
            sat_reg   <= b_clear_reg ? 1'b0 : sat_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = drive_reg;
    assign m_axis_tuser[0] = sat_reg;

    // ---------------- assertions ----------------
    logic [DRIVE_W-1:0] sel_limit;
    assign sel_limit = form_reg[1] ? DRIVE_W'(pos_limit_reg) : DRIVE_W'(inc_limit_reg);

    a_clear_history: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_load && a_clear_reg) |=> (last_err_reg == '0 && prev_err_reg == '0))
        else $error("error history not zeroed by clear item");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata == sel_limit || m_axis_tdata == DRIVE_W'(-sel_limit)))
        else $error("saturated result not at the limit");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata != {1'b1, {(DRIVE_W-1){1'b0}}}))
        else $error("drive outside symmetric range");

    a_stage_b_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !c_ready) |=> b_valid_reg)
        else $error("item dropped from product stage");

endmodule
